### rtl/bscd_pkg.sv
// Shared types, constants and the CRC byte update for the byte-stuffed CRC deframer.
`timescale 1ns / 1ps
`default_nettype none

package bscd_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CAP_BITS   = 16;

  localparam logic [7:0]  FLAG_BYTE    = 8'h7E;
  localparam logic [7:0]  ESC_BYTE     = 8'h7D;
  localparam logic [7:0]  STUFF_XOR    = 8'h20;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CAP_RESET    = 16'd4096;

  // One received byte with its end-of-buffer mark
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } bscd_item_t;

  // One result: payload byte and/or frame status
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       frame_done;
    logic       frame_ok;
  } bscd_result_t;

  // CRC-16/CCITT-FALSE update over one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/bscd_ifs.sv
// Handshake interfaces for the receive byte, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface bscd_rx_if;
  import bscd_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_end;
  modport source (output valid, output in_byte, output buffer_end, input ready);
  modport sink (input valid, input in_byte, input buffer_end, output ready);
endinterface

interface bscd_tx_if;
  import bscd_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       frame_done;
  logic       frame_ok;
  modport source (output valid, output out_byte, output out_valid, output frame_done,
                  output frame_ok, input ready);
  modport sink (input valid, input out_byte, input out_valid, input frame_done,
                input frame_ok, output ready);
endinterface

interface bscd_cfg_if;
  import bscd_pkg::*;
  logic                valid;
  logic                ready;
  logic [CAP_BITS-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/byte_stuffed_crc_deframer_top.sv
// Top level of the byte-stuffed CRC-16 deframer.
`timescale 1ns / 1ps
`default_nettype none

// Byte-stuffed frame receiver with CRC-16/CCITT-FALSE check (poly 0x1021, init
// 0xFFFF). Takes one received byte per transaction on rx, with buffer_end marking
// the last byte of a receive buffer. A leading 0x7E is skipped, 0x7D escapes the
// next byte (XOR 0x20), and bytes stop at the next 0x7E, at buffer end or once
// the unstuffed count reaches out_capacity. The two trailing CRC bytes are held
// back; payload bytes stream out on tx and each buffer yields one frame_done
// transaction whose frame_ok tells whether length and CRC were good. On
// frame_ok = 0 drop the payload already received for that frame. One byte is
// accepted every cycle while tx takes results; a stalled result holds the core,
// and rx stalls once the input register holds a byte as well. A byte's result
// passes the input register, then the result register loaded with the state
// update and byte-wide CRC step. Write out_capacity on cfg only while idle.
module byte_stuffed_crc_deframer_top (
  input  wire logic clk,
  input  wire logic rst,
  bscd_rx_if.sink   rx,
  bscd_tx_if.source tx,
  bscd_cfg_if.sink  cfg
);
  import bscd_pkg::*;

  logic [CAP_BITS-1:0] out_capacity;
  bscd_item_t          item;
  logic                item_valid;
  logic                item_take;

  // Capacity register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      out_capacity <= cfg.data;
    end
  end

  bscd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  bscd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .out_capacity (out_capacity),
    .item         (item),
    .item_valid   (item_valid),
    .item_take    (item_take),
    .tx           (tx)
  );

endmodule

`default_nettype wire

### rtl/bscd_in_stage.sv
// Input register: captures one received byte per transaction for the deframing core.
`timescale 1ns / 1ps
`default_nettype none

module bscd_in_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  bscd_rx_if.sink                  rx,
  output bscd_pkg::bscd_item_t     item,
  output logic                     item_valid,
  input  wire logic                item_take
);
  import bscd_pkg::*;

  // Accept when empty or when the held item moves on this cycle
  assign rx.ready = !item_valid || item_take;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (rx.ready) begin
      item_valid <= rx.valid;
    end
  end

  // Load payload on each transaction
  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      item.data <= rx.in_byte;
      item.last <= rx.buffer_end;
    end
  end

endmodule

`default_nettype wire

### rtl/bscd_core.sv
// Deframing core: flag/escape handling, two-byte CRC delay, CRC check and result register.
`timescale 1ns / 1ps
`default_nettype none

module bscd_core (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [bscd_pkg::CAP_BITS-1:0] out_capacity,
  input  wire bscd_pkg::bscd_item_t    item,
  input  wire logic                    item_valid,
  output logic                         item_take,
  bscd_tx_if.source                    tx
);
  import bscd_pkg::*;

  localparam int CMP_BITS = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_TAKE  = 2'd1;
  localparam logic [1:0] PH_DROP  = 2'd2;

  logic [1:0]            phase, phase_next;
  logic                  esc, esc_next;
  logic [15:0]           crc, crc_next;
  logic [7:0]            hold0, hold0_next, hold1, hold1_next;
  logic [COUNT_BITS-1:0] count, count_next;

  logic                  res_valid;
  bscd_result_t          res, res_next;

  // Frame state as seen by this byte, cleared at buffer start
  logic                  esc_c;
  logic [15:0]           crc_c;
  logic [7:0]            hold0_c, hold1_c;
  logic [COUNT_BITS-1:0] count_c;

  logic                  start;
  logic                  have_data, done, ok, emit, cap_hit;
  logic [7:0]            data_b;

  // Advance when the result register is free or drains this cycle
  assign item_take = item_valid && (!res_valid || tx.ready);

  always_comb begin
    start   = (phase == PH_START);
    esc_c   = start ? 1'b0 : esc;
    crc_c   = start ? CRC_INIT : crc;
    hold0_c = start ? 8'h00 : hold0;
    hold1_c = start ? 8'h00 : hold1;
    count_c = start ? '0 : count;

    esc_next   = esc_c;
    crc_next   = crc_c;
    hold0_next = hold0_c;
    hold1_next = hold1_c;
    count_next = count_c;
    phase_next = phase;

    have_data = 1'b0;
    done      = 1'b0;
    ok        = 1'b0;
    emit      = 1'b0;
    data_b    = item.data;
    cap_hit   = (CMP_BITS'(count_c) >= CMP_BITS'(out_capacity)) || (&count_c);

    if (start && item.data == FLAG_BYTE) begin
      // Skip leading flag; a lone flag is an empty frame
      phase_next = PH_TAKE;
      done       = item.last;
    end else if (start || phase == PH_TAKE) begin
      phase_next = PH_TAKE;
      priority if (esc_c) begin
        esc_next  = 1'b0;
        data_b    = item.data ^ STUFF_XOR;
        have_data = 1'b1;
      end else if (item.data == FLAG_BYTE) begin
        // Closing flag: check length and CRC
        done = 1'b1;
        ok   = (count_c >= COUNT_BITS'(2)) && (hold0_c == crc_c[15:8]) &&
               (hold1_c == crc_c[7:0]);
      end else if (item.data == ESC_BYTE) begin
        esc_next = 1'b1;
        done     = item.last;
      end else begin
        have_data = 1'b1;
      end

      if (have_data) begin
        if (cap_hit) begin
          done = 1'b1;
        end else begin
          // Shift through the two-byte delay, fold outgoing byte into CRC
          emit       = (count_c >= COUNT_BITS'(2));
          crc_next   = emit ? crc_byte(crc_c, hold0_c) : crc_c;
          hold0_next = hold1_c;
          hold1_next = data_b;
          count_next = count_c + COUNT_BITS'(1);
          if (item.last) begin
            done = 1'b1;
            ok   = (count_next >= COUNT_BITS'(2)) && (hold0_next == crc_next[15:8]) &&
                   (hold1_next == crc_next[7:0]);
          end
        end
      end
    end

    if (done) begin
      phase_next = PH_DROP;
    end
    if (item.last) begin
      phase_next = PH_START;
    end

    res_next.out_byte   = emit ? hold0_c : 8'h00;
    res_next.out_valid  = emit;
    res_next.frame_done = done;
    res_next.frame_ok   = done && ok;
  end

  // Update frame state per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      esc   <= 1'b0;
      crc   <= CRC_INIT;
      hold0 <= 8'h00;
      hold1 <= 8'h00;
      count <= '0;
    end else if (item_take) begin
      phase <= phase_next;
      esc   <= esc_next;
      crc   <= crc_next;
      hold0 <= hold0_next;
      hold1 <= hold1_next;
      count <= count_next;
    end
  end

  // Hold result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_take) begin
      res_valid <= res_next.out_valid || res_next.frame_done;
    end else if (tx.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res <= res_next;
    end
  end

  assign tx.valid      = res_valid;
  assign tx.out_byte   = res.out_byte;
  assign tx.out_valid  = res.out_valid;
  assign tx.frame_done = res.frame_done;
  assign tx.frame_ok   = res.frame_ok;

endmodule

`default_nettype wire

### dv/tb_byte_stuffed_crc_deframer_top.sv
// Self-checking testbench for the byte-stuffed CRC-16 deframer: directed table, random buffers.
`timescale 1ns / 1ps

module tb_byte_stuffed_crc_deframer_top;
  import bscd_pkg::*;

  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          SETTLE_CYCLES   = 4;
  localparam int          PHASE_ITEMS     = 120;
  localparam int          NUM_PHASES      = 8;
  localparam int          LONG_RUN_BYTES  = 200;
  localparam int unsigned COUNT_MAX       = (1 << COUNT_BITS) - 1;

  typedef enum logic [1:0] {SCAN_START, SCAN_TAKE, SCAN_DROP} scan_state_t;

  // How a transaction's expectation is formed: from the predictor, or typed in the table
  typedef enum logic [1:0] {PIN_PREDICT, PIN_NONE, PIN_RESULT} pin_kind_t;

  typedef struct {
    pin_kind_t    kind;
    bscd_result_t res;
  } pin_t;

  typedef struct {
    logic [7:0]   data;
    logic         last;
    pin_kind_t    kind;
    bscd_result_t res;
  } dir_row_t;

  localparam bscd_result_t R_NONE = '0;
  localparam bscd_result_t R_ERR  = '{out_byte: 8'h00, out_valid: 1'b0, frame_done: 1'b1,
                                      frame_ok: 1'b0};
  localparam bscd_result_t R_GOOD = '{out_byte: 8'h00, out_valid: 1'b0, frame_done: 1'b1,
                                      frame_ok: 1'b1};

  // Directed buffers: flag pair, flag-only, one byte, trailing escape, the "123456789"
  // check frame (CRC 0x29B1), then stuffed flag/escape bytes, closing flag and ignored tail
  dir_row_t directed_rows [26] = '{
    '{8'h7E, 1'b0, PIN_NONE,    R_NONE},
    '{8'h7E, 1'b1, PIN_RESULT,  R_ERR },
    '{8'h7E, 1'b1, PIN_RESULT,  R_ERR },
    '{8'h00, 1'b1, PIN_RESULT,  R_ERR },
    '{8'h7D, 1'b1, PIN_RESULT,  R_ERR },
    '{8'h7E, 1'b0, PIN_NONE,    R_NONE},
    '{8'h31, 1'b0, PIN_PREDICT, R_NONE},
    '{8'h32, 1'b0, PIN_PREDICT, R_NONE},
    '{8'h33, 1'b0, PIN_PREDICT, R_NONE},
    '{8'h34, 1'b0, PIN_PREDICT, R_NONE},
    '{8'h35, 1'b0, PIN_PREDICT, R_NONE},
    '{8'h36, 1'b0, PIN_PREDICT, R_NONE},
    '{8'h37, 1'b0, PIN_PREDICT, R_NONE},
    '{8'h38, 1'b0, PIN_PREDICT, R_NONE},
    '{8'h39, 1'b0, PIN_PREDICT, R_NONE},
    '{8'h29, 1'b0, PIN_PREDICT, R_NONE},
    '{8'hB1, 1'b0, PIN_PREDICT, R_NONE},
    '{8'h7E, 1'b1, PIN_RESULT,  R_GOOD},
    '{8'hFF, 1'b0, PIN_PREDICT, R_NONE},
    '{8'h7D, 1'b0, PIN_PREDICT, R_NONE},
    '{8'h5E, 1'b0, PIN_PREDICT, R_NONE},
    '{8'h7D, 1'b0, PIN_PREDICT, R_NONE},
    '{8'h5D, 1'b0, PIN_PREDICT, R_NONE},
    '{8'h00, 1'b0, PIN_PREDICT, R_NONE},
    '{8'h7E, 1'b0, PIN_PREDICT, R_NONE},
    '{8'hAA, 1'b1, PIN_NONE,    R_NONE}
  };

  logic clk;
  logic rst;

  bscd_rx_if  rx_ch();
  bscd_tx_if  tx_ch();
  bscd_cfg_if cfg_ch();

  byte_stuffed_crc_deframer_top u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .tx  (tx_ch),
    .cfg (cfg_ch)
  );

  // Deframer state as the testbench tracks it
  scan_state_t         scan_state = SCAN_START;
  logic                esc_pending = 1'b0;
  logic [15:0]         frame_crc = CRC_INIT;
  logic [7:0]          held_bytes [2] = '{8'h00, 8'h00};
  int unsigned         unstuffed_cnt = 0;
  logic [CAP_BITS-1:0] capacity = CAP_RESET;

  bscd_result_t expected_q [$];
  pin_t         pin_q [$];

  int fail_count = 0;
  int bytes_sent;
  int buffers_sent;
  int results_checked = 0;
  int good_frames = 0;
  int bad_frames = 0;
  int idle_pct;
  int stall_pct;
  int quiet_cycles = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // CRC-16/CCITT-FALSE over one byte, MSB first
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // The two held bytes must equal the CRC of everything streamed before them
  function automatic bit held_crc_matches();
    return unstuffed_cnt >= 2 && held_bytes[0] == frame_crc[15:8] &&
           held_bytes[1] == frame_crc[7:0];
  endfunction

  // Advance the tracked state by one received byte; return 1 when a result is due
  function automatic bit deframe_step(input logic [7:0] raw, input logic last_in,
                                      output bscd_result_t res);
    logic [7:0] b;
    bit proceed, have_data, done, ok, emit;
    logic [7:0] emit_byte;
    b = raw;
    proceed = 1'b0;
    have_data = 1'b0;
    done = 1'b0;
    ok = 1'b0;
    emit = 1'b0;
    emit_byte = 8'h00;
    if (scan_state == SCAN_START) begin
      esc_pending = 1'b0;
      frame_crc = CRC_INIT;
      held_bytes[0] = 8'h00;
      held_bytes[1] = 8'h00;
      unstuffed_cnt = 0;
      scan_state = SCAN_TAKE;
      // skip a leading flag; alone in its buffer it is an empty frame
      if (b == FLAG_BYTE) begin
        done = last_in;
      end else begin
        proceed = 1'b1;
      end
    end else if (scan_state == SCAN_TAKE) begin
      proceed = 1'b1;
    end
    if (proceed) begin
      if (esc_pending) begin
        esc_pending = 1'b0;
        b = b ^ STUFF_XOR;
        have_data = 1'b1;
      end else if (b == FLAG_BYTE) begin
        done = 1'b1;
        ok = held_crc_matches();
      end else if (b == ESC_BYTE) begin
        esc_pending = 1'b1;
        done = last_in;
      end else begin
        have_data = 1'b1;
      end
    end
    if (have_data) begin
      if (unstuffed_cnt >= capacity || unstuffed_cnt >= COUNT_MAX) begin
        done = 1'b1;
      end else begin
        // release the oldest held byte once two are held
        if (unstuffed_cnt >= 2) begin
          emit = 1'b1;
          emit_byte = held_bytes[0];
          frame_crc = crc16_update(frame_crc, held_bytes[0]);
        end
        held_bytes[0] = held_bytes[1];
        held_bytes[1] = b;
        unstuffed_cnt++;
        if (last_in) begin
          done = 1'b1;
          ok = held_crc_matches();
        end
      end
    end
    if (done) begin
      scan_state = SCAN_DROP;
    end
    if (last_in) begin
      scan_state = SCAN_START;
    end
    res.out_byte = emit_byte;
    res.out_valid = emit;
    res.frame_done = done;
    res.frame_ok = done && ok;
    return emit || done;
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %02h actual %02h", $time, field, want, got);
      fail_count++;
    end
  endfunction

  // Track accepted transactions on all three channels and check results
  always @(posedge clk) begin : scoreboard
    pin_t         pin;
    bscd_result_t predicted;
    bscd_result_t want;
    bscd_result_t got;
    bit           due;
    if (!rst) begin
      if (rx_ch.valid && rx_ch.ready) begin
        pin = pin_q.pop_front();
        due = deframe_step(rx_ch.in_byte, rx_ch.buffer_end, predicted);
        case (pin.kind)
          PIN_RESULT: begin
            expected_q.push_back(pin.res);
          end
          PIN_PREDICT: begin
            if (due) expected_q.push_back(predicted);
          end
          default: ;
        endcase
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        capacity = cfg_ch.data;
      end
      if (tx_ch.valid && tx_ch.ready) begin
        got.out_byte = tx_ch.out_byte;
        got.out_valid = tx_ch.out_valid;
        got.frame_done = tx_ch.frame_done;
        got.frame_ok = tx_ch.frame_ok;
        if (got.frame_done) begin
          if (got.frame_ok) good_frames++;
          else bad_frames++;
        end
        if (expected_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none actual %p", $time, got);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("out_byte", want.out_byte, got.out_byte);
          check_field("out_valid", want.out_valid, got.out_valid);
          check_field("frame_done", want.frame_done, got.frame_done);
          check_field("frame_ok", want.frame_ok, got.frame_ok);
          results_checked++;
        end
      end
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    tx_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles, %0d results outstanding", $time,
               WATCHDOG_LIMIT, expected_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Drive one byte, after a random gap; leave valid high on return
  task automatic send_byte(input logic [7:0] b, input logic last_b, input pin_t pin);
    while ($urandom_range(99) < idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pin_q.push_back(pin);
    rx_ch.valid <= 1'b1;
    rx_ch.in_byte <= b;
    rx_ch.buffer_end <= last_b;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
    if (last_b) buffers_sent++;
  endtask

  // Drop valid, wait for all results, then let the pipeline empty
  task automatic settle();
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random content, biased toward flag and escape bytes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Build one receive buffer: mostly well-formed stuffed frames, some corrupt, some noise
  task automatic send_random_buffer();
    logic [7:0]  raw [$];
    logic [7:0]  b;
    logic [15:0] crc;
    pin_t        pin;
    int          kind;
    int          len;
    int          tail;
    pin.kind = PIN_PREDICT;
    pin.res = R_NONE;
    kind = $urandom_range(99);
    if (kind < 75) begin
      if ($urandom_range(9) != 0) raw.push_back(FLAG_BYTE);
      len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(10);
      crc = CRC_INIT;
      for (int n = 0; n < len + 2; n++) begin
        if (n < len) begin
          b = pick_byte();
          crc = crc16_update(crc, b);
        end else begin
          b = (n == len) ? crc[15:8] : crc[7:0];
        end
        // corrupt the low CRC byte in some frames
        if (kind >= 65 && n == len + 1) b = b ^ 8'($urandom_range(1, 255));
        if (b == FLAG_BYTE || b == ESC_BYTE) begin
          raw.push_back(ESC_BYTE);
          raw.push_back(b ^ STUFF_XOR);
        end else begin
          raw.push_back(b);
        end
      end
      tail = $urandom_range(2);
      if (tail != 0) raw.push_back(FLAG_BYTE);
      if (tail == 2) begin
        repeat ($urandom_range(1, 3)) raw.push_back(pick_byte());
      end
    end else begin
      repeat ($urandom_range(1, 16)) raw.push_back(pick_byte());
    end
    foreach (raw[i]) begin
      send_byte(raw[i], i == raw.size() - 1, pin);
    end
  endtask

  // Stimulus
  initial begin : stimulus
    pin_t              pin;
    logic [7:0]        b;
    logic [CAP_BITS-1:0] cap_plan [NUM_PHASES];
    int                phase_start;
    cap_plan = '{16'd0, 16'hFFFF, 16'd2, 16'd1, 16'd0, 16'd0, 16'd3, CAP_RESET};
    rst <= 1'b1;
    rx_ch.valid <= 1'b0;
    rx_ch.in_byte <= 8'h00;
    rx_ch.buffer_end <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    bytes_sent = 0;
    buffers_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table at the reset capacity
    foreach (directed_rows[i]) begin
      pin.kind = directed_rows[i].kind;
      pin.res = directed_rows[i].res;
      send_byte(directed_rows[i].data, directed_rows[i].last, pin);
    end
    settle();

    // One long unstuffed buffer at the largest capacity
    write_capacity(16'hFFFF);
    pin.kind = PIN_PREDICT;
    pin.res = R_NONE;
    send_byte(FLAG_BYTE, 1'b0, pin);
    for (int n = 0; n < LONG_RUN_BYTES; n++) begin
      do b = 8'($urandom_range(255)); while (b == FLAG_BYTE || b == ESC_BYTE);
      send_byte(b, 1'b0, pin);
    end
    send_byte(FLAG_BYTE, 1'b1, pin);
    settle();

    // Random phases, each with its own capacity and idling mix
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 4 || p == 5) begin
        write_capacity(CAP_BITS'($urandom_range(4, 24)));
      end else begin
        write_capacity(cap_plan[p]);
      end
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS) send_random_buffer();
      settle();
    end

    $display("covered %0d bytes in %0d buffers over %0d capacity settings", bytes_sent,
             buffers_sent, NUM_PHASES + 2);
    $display("checked %0d results: %0d frames good, %0d frames rejected, %0d mismatches",
             results_checked, good_frames, bad_frames, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
